### hw/rtl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared constants, request/status codes, sequencer commands and the
// helpers that locate a block's free bit in the packed bitmap memory.
// ============================================================================
package bba_pkg;

  // Store geometry
  localparam int MaxLevel = 10;
  localparam int Cap      = 1 << MaxLevel;
  localparam int AW       = MaxLevel;             // unit offset bits
  localparam int LW       = $clog2(MaxLevel + 1); // level bits
  localparam int SW       = MaxLevel + 1;         // unit count bits
  localparam int OffW     = 10;                   // block_offset field
  localparam int SizeW    = 11;                   // alloc_size field

  // Free bitmap packing: each level starts on a fresh 32-bit word
  localparam int WordW = 32;
  localparam int BitW  = 5;
  localparam int WIW   = (MaxLevel > BitW) ? MaxLevel - BitW : 1;

  function automatic int level_words(int k);
    int n;
    n = (Cap >> k) >> BitW;
    return (n > 0) ? n : 1;
  endfunction

  function automatic int base_of(int lvl);
    int s;
    s = 0;
    for (int k = 0; k <= MaxLevel; k++) begin
      if (k < lvl) s = s + level_words(k);
    end
    return s;
  endfunction

  localparam int FmWords = base_of(MaxLevel + 1);
  localparam int FAW     = $clog2(FmWords);

  function automatic logic [FAW-1:0] word_base(logic [LW-1:0] lvl);
    return FAW'(base_of(int'(lvl)));
  endfunction

  function automatic logic [WIW-1:0] last_word(logic [LW-1:0] lvl);
    return WIW'(level_words(int'(lvl)) - 1);
  endfunction

  // Smallest level whose block holds size units
  function automatic logic [LW-1:0] level_for(logic [SizeW-1:0] size);
    int l;
    l = 0;
    for (int k = 0; k < MaxLevel; k++) begin
      if ((1 << k) < int'(size)) l = k + 1;
    end
    return LW'(l);
  endfunction

  // Request kinds
  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqClaim = 2'd2;

  // Result status
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StReject   = 2'd1;
  localparam logic [1:0] StNotAlloc = 2'd2;

  // Sequencer commands to the datapath
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_A_INIT,
    OP_A_RD,
    OP_A_NEXTW,
    OP_A_NEXTL,
    OP_A_TAKE,
    OP_F_RDTAG,
    OP_F_REL,
    OP_F_RDB,
    OP_F_MERGE,
    OP_NODE_RD,
    OP_SET_WR,
    OP_C_INIT,
    OP_C_RD,
    OP_C_HIT,
    OP_C_DEC,
    OP_SP_RD,
    OP_TAKE,
    OP_REJECT,
    OP_FREE_OK,
    OP_FREE_ERR
  } bba_op_e;

  typedef struct packed {
    bba_op_e op;
  } bba_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       size_bad;
    logic       claim_bad;
    logic       off_big;
    logic       lvl_is_target;
    logic       lvl_is_max;
    logic       word_nz;
    logic       word_last;
    logic       bit_set;
    logic       tag_used;
    logic       clr_done;
    logic       out_free;
  } bba_stat_t;

endpackage

### hw/rtl/bba_ram.sv
// ============================================================================
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, then register read data on enable
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bba_dp.sv
// ============================================================================
// bba_dp
// Allocator datapath: request registers, level/offset walkers, the packed
// free bitmap memory, the per-offset tag memory and the result register.
// ============================================================================
module bba_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bba_pkg::bba_cmd_t       cmd_i,
  output bba_pkg::bba_stat_t      stat_o,
  input  logic [1:0]              req_type_i,
  input  logic [bba_pkg::SizeW-1:0] alloc_size_i,
  input  logic [bba_pkg::OffW-1:0]  block_offset_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [1:0]              status_o,
  output logic [bba_pkg::OffW-1:0]  result_offset_o,
  output logic [bba_pkg::SW-1:0]    allocated_units_o
);

  localparam int AW  = bba_pkg::AW;
  localparam int LW  = bba_pkg::LW;
  localparam int SW  = bba_pkg::SW;
  localparam int FAW = bba_pkg::FAW;
  localparam int WIW = bba_pkg::WIW;
  localparam int BW  = bba_pkg::BitW;
  localparam int WW  = bba_pkg::WordW;

  bba_pkg::bba_op_e op;

  // Request and walker registers
  logic [1:0]     kind_q;
  logic           size_bad_q;
  logic           off_big_q;
  logic [AW-1:0]  off_q;
  logic [LW-1:0]  target_q;
  logic [LW-1:0]  lvl_q;
  logic [AW-1:0]  cur_q;
  logic [WIW-1:0] widx_q;
  logic [FAW-1:0] fw_q;
  logic [BW-1:0]  fb_q;

  // Control state
  logic [AW-1:0]  clr_q;
  logic [SW-1:0]  total_q, total_d;
  logic           out_valid_q, out_valid_d;
  logic [1:0]     status_q;
  logic [AW-1:0]  res_q;
  logic [SW-1:0]  units_q;

  // Memory ports
  logic           fm_we, fm_re;
  logic [FAW-1:0] fm_waddr, fm_raddr;
  logic [WW-1:0]  fm_wdata, fm_rdata;
  logic           tg_we, tg_re;
  logic [AW-1:0]  tg_waddr;
  logic [LW:0]    tg_wdata, tg_rdata;

  // Node locate
  logic [LW-1:0]  lvl_m1;
  logic [AW-1:0]  upper;
  logic           take_hi;
  logic [LW-1:0]  node_lvl;
  logic [AW-1:0]  node_off;
  logic [AW-1:0]  node_blk;
  logic [FAW-1:0] node_word;
  logic [BW-1:0]  node_bit;
  logic [FAW-1:0] scan_word;
  logic [BW-1:0]  lo_bit;
  logic [AW-1:0]  found_off;
  logic [LW-1:0]  tag_lvl;
  logic [SW-1:0]  blk_size;

  assign op = cmd_i.op;

  // Split step: pick the half that is given back
  assign lvl_m1  = lvl_q - LW'(1);
  assign upper   = cur_q + (AW'(1) << lvl_m1);
  assign take_hi = (off_q >= upper);

  always_comb begin
    node_lvl = lvl_q;
    node_off = cur_q;
    case (op)
      bba_pkg::OP_C_RD:  node_off = off_q;
      bba_pkg::OP_F_RDB: node_off = cur_q ^ (AW'(1) << lvl_q);
      bba_pkg::OP_SP_RD: begin
        node_lvl = lvl_m1;
        node_off = take_hi ? cur_q : upper;
      end
      default: ;
    endcase
  end

  assign node_blk  = node_off >> node_lvl;
  assign node_word = bba_pkg::word_base(node_lvl) + FAW'(node_blk >> BW);
  assign node_bit  = BW'(node_blk);
  assign scan_word = bba_pkg::word_base(lvl_q) + FAW'(widx_q);

  // Lowest free bit of the scanned word
  always_comb begin
    lo_bit = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (fm_rdata[i]) lo_bit = BW'(i);
    end
  end

  assign found_off = AW'({widx_q, lo_bit}) << lvl_q;
  assign tag_lvl   = (tg_rdata[LW-1:0] > LW'(bba_pkg::MaxLevel)) ?
                     LW'(bba_pkg::MaxLevel) : tg_rdata[LW-1:0];
  assign blk_size  = SW'(1) << target_q;

  // Free bitmap memory access
  always_comb begin
    fm_re    = 1'b0;
    fm_raddr = node_word;
    fm_we    = 1'b0;
    fm_waddr = fw_q;
    fm_wdata = fm_rdata;
    case (op)
      bba_pkg::OP_CLR: begin
        fm_we    = (int'(clr_q) < bba_pkg::FmWords);
        fm_waddr = FAW'(clr_q);
        fm_wdata = (FAW'(clr_q) == bba_pkg::word_base(LW'(bba_pkg::MaxLevel))) ?
                   WW'(1) : '0;
      end
      bba_pkg::OP_A_RD: begin
        fm_re    = 1'b1;
        fm_raddr = scan_word;
      end
      bba_pkg::OP_C_RD, bba_pkg::OP_F_RDB, bba_pkg::OP_NODE_RD,
      bba_pkg::OP_SP_RD: fm_re = 1'b1;
      bba_pkg::OP_A_TAKE: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rdata & ~(WW'(1) << lo_bit);
      end
      bba_pkg::OP_C_HIT, bba_pkg::OP_F_MERGE: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rdata & ~(WW'(1) << fb_q);
      end
      bba_pkg::OP_SET_WR: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rdata | (WW'(1) << fb_q);
      end
      default: ;
    endcase
  end

  // Tag memory access
  always_comb begin
    tg_re    = (op == bba_pkg::OP_F_RDTAG);
    tg_we    = 1'b0;
    tg_waddr = off_q;
    tg_wdata = '0;
    case (op)
      bba_pkg::OP_CLR: begin
        tg_we    = 1'b1;
        tg_waddr = clr_q;
      end
      bba_pkg::OP_F_REL: tg_we = 1'b1;
      bba_pkg::OP_TAKE: begin
        tg_we    = 1'b1;
        tg_waddr = cur_q;
        tg_wdata = {1'b1, target_q};
      end
      default: ;
    endcase
  end

  bba_ram #(.Width(WW), .Depth(bba_pkg::FmWords)) u_fm_ram (
    .clk_i  (clk_i),
    .we_i   (fm_we),
    .waddr_i(fm_waddr),
    .wdata_i(fm_wdata),
    .re_i   (fm_re),
    .raddr_i(fm_raddr),
    .rdata_o(fm_rdata)
  );

  bba_ram #(.Width(LW + 1), .Depth(bba_pkg::Cap)) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tg_we),
    .waddr_i(tg_waddr),
    .wdata_i(tg_wdata),
    .re_i   (tg_re),
    .raddr_i(off_q),
    .rdata_o(tg_rdata)
  );

  // Running total and result handshake
  always_comb begin
    total_d = total_q;
    case (op)
      bba_pkg::OP_F_REL: total_d = total_q - (SW'(1) << tag_lvl);
      bba_pkg::OP_TAKE:  total_d = total_q + blk_size;
      default: ;
    endcase
    out_valid_d = out_valid_q & out_stall_i;
    if (op == bba_pkg::OP_TAKE || op == bba_pkg::OP_REJECT ||
        op == bba_pkg::OP_FREE_OK || op == bba_pkg::OP_FREE_ERR) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == bba_pkg::OP_CLR) clr_q <= clr_q + AW'(1);
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walker and result payload
  always_ff @(posedge clk_i) begin
    if (fm_re) begin
      fw_q <= fm_raddr;
      fb_q <= node_bit;
    end
    case (op)
      bba_pkg::OP_LOAD: begin
        kind_q     <= req_type_i;
        off_q      <= AW'(block_offset_i);
        off_big_q  <= (int'(block_offset_i) >= bba_pkg::Cap);
        target_q   <= bba_pkg::level_for(alloc_size_i);
        size_bad_q <= (alloc_size_i == '0) || (int'(alloc_size_i) > bba_pkg::Cap);
      end
      bba_pkg::OP_A_INIT: begin
        lvl_q  <= target_q;
        widx_q <= '0;
      end
      bba_pkg::OP_A_NEXTW: widx_q <= widx_q + WIW'(1);
      bba_pkg::OP_A_NEXTL: begin
        lvl_q  <= lvl_q + LW'(1);
        widx_q <= '0;
      end
      bba_pkg::OP_A_TAKE: begin
        cur_q <= found_off;
        off_q <= found_off;
      end
      bba_pkg::OP_F_REL: begin
        lvl_q <= tag_lvl;
        cur_q <= off_q;
      end
      bba_pkg::OP_F_MERGE: begin
        cur_q <= cur_q & ~(AW'(1) << lvl_q);
        lvl_q <= lvl_q + LW'(1);
      end
      bba_pkg::OP_C_INIT: lvl_q <= LW'(bba_pkg::MaxLevel);
      bba_pkg::OP_C_HIT:  cur_q <= (off_q >> lvl_q) << lvl_q;
      bba_pkg::OP_C_DEC:  lvl_q <= lvl_m1;
      bba_pkg::OP_SP_RD: begin
        lvl_q <= lvl_m1;
        if (take_hi) cur_q <= upper;
      end
      bba_pkg::OP_TAKE: begin
        status_q <= bba_pkg::StOk;
        res_q    <= cur_q;
        units_q  <= total_d;
      end
      bba_pkg::OP_REJECT: begin
        status_q <= bba_pkg::StReject;
        res_q    <= '0;
        units_q  <= total_q;
      end
      bba_pkg::OP_FREE_OK: begin
        status_q <= bba_pkg::StOk;
        res_q    <= '0;
        units_q  <= total_q;
      end
      bba_pkg::OP_FREE_ERR: begin
        status_q <= bba_pkg::StNotAlloc;
        res_q    <= '0;
        units_q  <= total_q;
      end
      default: ;
    endcase
  end

  // Status to the sequencer
  always_comb begin
    stat_o.kind          = kind_q;
    stat_o.size_bad      = size_bad_q;
    stat_o.claim_bad     = (({1'b0, off_q} & (blk_size - SW'(1))) != '0) ||
                           (({1'b0, off_q} + blk_size) > SW'(bba_pkg::Cap));
    stat_o.off_big       = off_big_q;
    stat_o.lvl_is_target = (lvl_q == target_q);
    stat_o.lvl_is_max    = (lvl_q == LW'(bba_pkg::MaxLevel));
    stat_o.word_nz       = (fm_rdata != '0);
    stat_o.word_last     = (widx_q == bba_pkg::last_word(lvl_q));
    stat_o.bit_set       = fm_rdata[fb_q];
    stat_o.tag_used      = tg_rdata[LW];
    stat_o.clr_done      = (clr_q == AW'(bba_pkg::Cap - 1));
    stat_o.out_free      = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign result_offset_o   = bba_pkg::OffW'(res_q);
  assign allocated_units_o = units_q;

endmodule

### hw/rtl/bba_ctrl.sv
// ============================================================================
// bba_ctrl
// Allocator sequencer: clearing pass, request dispatch, bitmap scan, split,
// merge and claim walks, and result posting.
// ============================================================================
module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bba_pkg::bba_stat_t stat_i,
  output bba_pkg::bba_cmd_t  cmd_o
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_A_RD   = 5'd3;
  localparam logic [4:0] S_A_CHK  = 5'd4;
  localparam logic [4:0] S_SP_RD  = 5'd5;
  localparam logic [4:0] S_SP_WR  = 5'd6;
  localparam logic [4:0] S_TAKE   = 5'd7;
  localparam logic [4:0] S_REJ    = 5'd8;
  localparam logic [4:0] S_F_TAG  = 5'd9;
  localparam logic [4:0] S_F_LOOP = 5'd10;
  localparam logic [4:0] S_F_BCHK = 5'd11;
  localparam logic [4:0] S_F_SET  = 5'd12;
  localparam logic [4:0] S_F_SETW = 5'd13;
  localparam logic [4:0] S_F_FIN  = 5'd14;
  localparam logic [4:0] S_F_ERR  = 5'd15;
  localparam logic [4:0] S_C_RD   = 5'd16;
  localparam logic [4:0] S_C_CHK  = 5'd17;

  logic [4:0] state_q, state_d;
  bba_pkg::bba_op_e op;

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o.op   = op;

  // Next state and command
  always_comb begin
    state_d = state_q;
    op      = bba_pkg::OP_NONE;
    unique case (state_q)
      S_CLR: begin
        op = bba_pkg::OP_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op      = bba_pkg::OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.kind)
          bba_pkg::ReqAlloc: begin
            if (stat_i.size_bad) state_d = S_REJ;
            else begin
              op      = bba_pkg::OP_A_INIT;
              state_d = S_A_RD;
            end
          end
          bba_pkg::ReqFree: begin
            if (stat_i.off_big) state_d = S_F_ERR;
            else begin
              op      = bba_pkg::OP_F_RDTAG;
              state_d = S_F_TAG;
            end
          end
          bba_pkg::ReqClaim: begin
            if (stat_i.size_bad || stat_i.claim_bad) state_d = S_REJ;
            else begin
              op      = bba_pkg::OP_C_INIT;
              state_d = S_C_RD;
            end
          end
          default: state_d = S_REJ;
        endcase
      end
      S_A_RD: begin
        op      = bba_pkg::OP_A_RD;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat_i.word_nz) begin
          op      = bba_pkg::OP_A_TAKE;
          state_d = stat_i.lvl_is_target ? S_TAKE : S_SP_RD;
        end else if (!stat_i.word_last) begin
          op      = bba_pkg::OP_A_NEXTW;
          state_d = S_A_RD;
        end else if (stat_i.lvl_is_max) begin
          state_d = S_REJ;
        end else begin
          op      = bba_pkg::OP_A_NEXTL;
          state_d = S_A_RD;
        end
      end
      S_SP_RD: begin
        op      = bba_pkg::OP_SP_RD;
        state_d = S_SP_WR;
      end
      S_SP_WR: begin
        op      = bba_pkg::OP_SET_WR;
        state_d = stat_i.lvl_is_target ? S_TAKE : S_SP_RD;
      end
      S_TAKE: begin
        if (stat_i.out_free) begin
          op      = bba_pkg::OP_TAKE;
          state_d = S_IDLE;
        end
      end
      S_REJ: begin
        if (stat_i.out_free) begin
          op      = bba_pkg::OP_REJECT;
          state_d = S_IDLE;
        end
      end
      S_F_TAG: begin
        if (!stat_i.tag_used) state_d = S_F_ERR;
        else begin
          op      = bba_pkg::OP_F_REL;
          state_d = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (stat_i.lvl_is_max) state_d = S_F_SET;
        else begin
          op      = bba_pkg::OP_F_RDB;
          state_d = S_F_BCHK;
        end
      end
      S_F_BCHK: begin
        if (stat_i.bit_set) begin
          op      = bba_pkg::OP_F_MERGE;
          state_d = S_F_LOOP;
        end else begin
          state_d = S_F_SET;
        end
      end
      S_F_SET: begin
        op      = bba_pkg::OP_NODE_RD;
        state_d = S_F_SETW;
      end
      S_F_SETW: begin
        op      = bba_pkg::OP_SET_WR;
        state_d = S_F_FIN;
      end
      S_F_FIN: begin
        if (stat_i.out_free) begin
          op      = bba_pkg::OP_FREE_OK;
          state_d = S_IDLE;
        end
      end
      S_F_ERR: begin
        if (stat_i.out_free) begin
          op      = bba_pkg::OP_FREE_ERR;
          state_d = S_IDLE;
        end
      end
      S_C_RD: begin
        op      = bba_pkg::OP_C_RD;
        state_d = S_C_CHK;
      end
      S_C_CHK: begin
        if (stat_i.bit_set) begin
          op      = bba_pkg::OP_C_HIT;
          state_d = stat_i.lvl_is_target ? S_TAKE : S_SP_RD;
        end else if (stat_i.lvl_is_target) begin
          state_d = S_REJ;
        end else begin
          op      = bba_pkg::OP_C_DEC;
          state_d = S_C_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else         state_q <= state_d;
  end

endmodule

### hw/rtl/buddy_block_allocator.sv
// ============================================================================
// buddy_block_allocator
// Power-of-two buddy allocator over a store of 1024 units.
// ============================================================================
// Requests enter on the input channel (req_type_i, alloc_size_i,
// block_offset_i) with in_valid_i / in_stall_o; a transfer happens on a clock
// edge with valid high and stall low. Each request gives exactly one result
// transfer (status_o, result_offset_o, allocated_units_o) on out_valid_o /
// out_stall_i, in request order.
// One request is worked at a time. Each bitmap word scanned, level searched,
// level split or buddy merged takes a memory read followed by a check or write.
// An allocate scans bitmap words and splits levels; a free merges levels, or
// ends early for an unallocated offset; a claim searches levels and splits
// them; a rejected size, alignment or kind is answered without a walk.
// in_stall_o is low only in the idle state, which is entered after each result
// is posted, so a new request is taken only after the previous one's result
// is posted. After reset a clearing pass initializes both memories;
// in_stall_o is held high until it ends.
// A result waiting under out_stall_i holds its payload; the next request is
// taken meanwhile and its result is posted once the output register frees up.
// ============================================================================
module buddy_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [bba_pkg::SizeW-1:0] alloc_size_i,
  input  logic [bba_pkg::OffW-1:0]  block_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [bba_pkg::OffW-1:0]  result_offset_o,
  output logic [bba_pkg::SW-1:0]    allocated_units_o
);

  bba_pkg::bba_cmd_t  cmd;
  bba_pkg::bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bba_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_type_i),
    .alloc_size_i     (alloc_size_i),
    .block_offset_i   (block_offset_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .result_offset_o  (result_offset_o),
    .allocated_units_o(allocated_units_o)
  );

endmodule
